FILE: rtl/dbgu_pkg.sv
// Types, register offsets and status codes shared by the debug UART register block.
package dbgu_pkg;

	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_RX    = 2'd2;

	localparam logic [8:0] OFS_CTRL   = 9'h000;
	localparam logic [8:0] OFS_MODE   = 9'h004;
	localparam logic [8:0] OFS_IEN    = 9'h008;
	localparam logic [8:0] OFS_IDIS   = 9'h00C;
	localparam logic [8:0] OFS_IMASK  = 9'h010;
	localparam logic [8:0] OFS_STATUS = 9'h014;
	localparam logic [8:0] OFS_RHOLD  = 9'h018;
	localparam logic [8:0] OFS_THOLD  = 9'h01C;
	localparam logic [8:0] OFS_BAUD   = 9'h020;
	localparam logic [8:0] OFS_CID    = 9'h040;
	localparam logic [8:0] OFS_CIDX   = 9'h044;
	localparam logic [8:0] OFS_NTRST  = 9'h048;

	localparam logic [31:0] ST_RX_READY    = 32'h0000_0001;
	localparam logic [31:0] ST_TX_READY    = 32'h0000_0002;
	localparam logic [31:0] ST_TX_EMPTY    = 32'h0000_0200;
	localparam logic [31:0] ST_TXBUF_EMPTY = 32'h0000_0800;
	localparam logic [31:0] ST_RXBUF_FULL  = 32'h0000_1000;

	localparam int CT_RX_ON  = 4;
	localparam int CT_RX_OFF = 5;
	localparam int CT_TX_ON  = 6;
	localparam int CT_TX_OFF = 7;

	localparam logic CFG_CHIP_ID     = 1'b0;
	localparam logic CFG_CHIP_ID_EXT = 1'b1;

	localparam logic [31:0] CHIP_ID_RESET = 32'h275B_0940;

	typedef struct packed {
		logic [1:0]  mode;
		logic [8:0]  address_offset;
		logic [31:0] write_data;
		logic [7:0]  rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_line;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        rx_ready;
	} out_item_t;

endpackage

FILE: rtl/dbgu_if.sv
// Valid/ready channel interfaces for request and result items.
interface dbgu_in_if;
	import dbgu_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface dbgu_out_if;
	import dbgu_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/dbgu_regs.sv
// Register file and per-item decode of the debug UART.
module dbgu_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                step,
	input  dbgu_pkg::in_item_t  item,
	output dbgu_pkg::out_item_t result
);
	import dbgu_pkg::*;

	logic        rx_en_q, tx_en_q, rx_full_q;
	logic [31:0] mode_word_q, mask_q, ntrst_q, chip_id_q, chip_idx_q;
	logic [7:0]  rx_hold_q, tx_hold_q;
	logic [15:0] baud_q;

	logic        rx_en_d, tx_en_d, rx_full_d;
	logic [31:0] mode_word_d, mask_d, ntrst_d;
	logic [7:0]  rx_hold_d, tx_hold_d;
	logic [15:0] baud_d;
	logic [31:0] rd;
	logic        sent;
	logic [31:0] status_cur, status_nxt;

	always_comb begin
		status_cur = ST_TX_READY | ST_TX_EMPTY | ST_TXBUF_EMPTY;
		if (rx_full_q) begin
			status_cur = status_cur | ST_RX_READY | ST_RXBUF_FULL;
		end
	end

	always_comb begin
		rx_en_d     = rx_en_q;
		tx_en_d     = tx_en_q;
		rx_full_d   = rx_full_q;
		mode_word_d = mode_word_q;
		mask_d      = mask_q;
		ntrst_d     = ntrst_q;
		rx_hold_d   = rx_hold_q;
		tx_hold_d   = tx_hold_q;
		baud_d      = baud_q;
		rd          = '0;
		sent        = 1'b0;
		case (item.mode)
			MODE_READ: begin
				case (item.address_offset)
					OFS_MODE:   rd = mode_word_q;
					OFS_IMASK:  rd = mask_q;
					OFS_STATUS: rd = status_cur;
					OFS_RHOLD: begin
						rd        = {24'd0, rx_hold_q};
						rx_full_d = 1'b0;
					end
					OFS_BAUD:   rd = {16'd0, baud_q};
					OFS_CID:    rd = chip_id_q;
					OFS_CIDX:   rd = chip_idx_q;
					OFS_NTRST:  rd = ntrst_q;
					default:    rd = '0;
				endcase
			end
			MODE_WRITE: begin
				case (item.address_offset)
					OFS_CTRL: begin
						if (item.write_data[CT_RX_OFF]) begin
							rx_en_d = 1'b0;
						end else if (item.write_data[CT_RX_ON]) begin
							rx_en_d = 1'b1;
						end
						if (item.write_data[CT_TX_OFF]) begin
							tx_en_d = 1'b0;
						end else if (item.write_data[CT_TX_ON]) begin
							tx_en_d = 1'b1;
						end
					end
					OFS_MODE:  mode_word_d = item.write_data;
					OFS_IEN:   mask_d = mask_q | item.write_data;
					OFS_IDIS:  mask_d = mask_q & ~item.write_data;
					OFS_THOLD: begin
						if (tx_en_q) begin
							tx_hold_d = item.write_data[7:0];
							sent      = 1'b1;
						end
					end
					OFS_BAUD:  baud_d = item.write_data[15:0];
					OFS_NTRST: ntrst_d = item.write_data;
					default: ;
				endcase
			end
			MODE_RX: begin
				if (rx_en_q && !rx_full_q) begin
					rx_hold_d = item.rx_byte;
					rx_full_d = 1'b1;
				end
			end
			default: ;
		endcase

		status_nxt = ST_TX_READY | ST_TX_EMPTY | ST_TXBUF_EMPTY;
		if (rx_full_d) begin
			status_nxt = status_nxt | ST_RX_READY | ST_RXBUF_FULL;
		end
		result.read_data = rd;
		result.irq_line  = |(status_nxt & mask_d);
		result.tx_valid  = sent;
		result.tx_byte   = sent ? tx_hold_d : 8'd0;
		result.rx_ready  = rx_en_d && !rx_full_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_en_q     <= 1'b0;
			tx_en_q     <= 1'b0;
			rx_full_q   <= 1'b0;
			mode_word_q <= '0;
			mask_q      <= '0;
			ntrst_q     <= '0;
			rx_hold_q   <= '0;
			tx_hold_q   <= '0;
			baud_q      <= '0;
		end else if (step) begin
			rx_en_q     <= rx_en_d;
			tx_en_q     <= tx_en_d;
			rx_full_q   <= rx_full_d;
			mode_word_q <= mode_word_d;
			mask_q      <= mask_d;
			ntrst_q     <= ntrst_d;
			rx_hold_q   <= rx_hold_d;
			tx_hold_q   <= tx_hold_d;
			baud_q      <= baud_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_id_q  <= CHIP_ID_RESET;
			chip_idx_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHIP_ID:     chip_id_q <= cfg_data;
				CFG_CHIP_ID_EXT: chip_idx_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/debug_uart_register_block.sv
// Top level of the debug UART register block: input and result registers around the decode.
// One item (bus read, bus write or received byte) is taken per clock: the item is captured in
// an input register, decoded against the register state in one pass, and the result is held
// in an output register. Throughput is one item per cycle as long as results are taken; a
// stalled result holds both registers in place. The user must write chip id values through
// the configuration port only while no item is in flight; the block does not enforce this.
module debug_uart_register_block (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	dbgu_in_if.sink     in_ch,
	dbgu_out_if.source  out_ch
);
	import dbgu_pkg::*;

	logic      valid_s1, valid_s2;
	in_item_t  item_s1;
	out_item_t result_s2;
	out_item_t result;
	logic      advance;

	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	dbgu_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (advance),
		.item      (item_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1 <= in_ch.payload;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_ch.valid   = valid_s2;
	assign out_ch.payload = result_s2;

endmodule

FILE: bench/debug_uart_register_block_tb.sv
// Self-checking testbench for the debug UART register block: bus reads, writes and received bytes.
module debug_uart_register_block_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dbgu_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int LIMIT_CYCLES = 200_000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_STALL_CYCLES = 300;
	localparam int PHASE_ITEMS = 470;
	localparam int MAX_REPORTS = 10;

	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam int CT_CLR_STATUS = 8;
	localparam logic [31:0] ST_ERROR_BITS = 32'h0000_00E0;
	localparam logic [31:0] ST_TX_BITS = ST_TX_READY | ST_TXBUF_EMPTY | ST_TX_EMPTY;

	class dbgu_reg_shadow;
		logic [31:0] chip_id;
		logic [31:0] chip_id_ext;
		bit rx_on;
		bit tx_on;
		logic [31:0] mode_reg;
		logic [31:0] irq_mask;
		logic [31:0] status;
		logic [7:0] rx_hold;
		logic [7:0] tx_hold;
		logic [15:0] baud;
		logic [31:0] ntrst;
		out_item_t pending_responses[$];
		int mismatches;

		function new();
			chip_id = CHIP_ID_RESET;
			chip_id_ext = '0;
			rx_on = 1'b0;
			tx_on = 1'b0;
			mode_reg = '0;
			irq_mask = '0;
			status = ST_TX_BITS;
			rx_hold = '0;
			tx_hold = '0;
			baud = '0;
			ntrst = '0;
			mismatches = 0;
		endfunction

		function void set_chip_id(logic idx, logic [31:0] value);
			if (idx == CFG_CHIP_ID)
				chip_id = value;
			else
				chip_id_ext = value;
		endfunction

		function void note_request(in_item_t it);
			out_item_t r;
			logic [31:0] d;
			r = '0;
			d = it.write_data;
			case (it.mode)
				MODE_READ: begin
					case (it.address_offset)
						OFS_MODE:   r.read_data = mode_reg;
						OFS_IMASK:  r.read_data = irq_mask;
						OFS_STATUS: r.read_data = status;
						OFS_RHOLD: begin
							r.read_data = {24'h0, rx_hold};
							status &= ~(ST_RX_READY | ST_RXBUF_FULL);
						end
						OFS_BAUD:   r.read_data = {16'h0, baud};
						OFS_CID:    r.read_data = chip_id;
						OFS_CIDX:   r.read_data = chip_id_ext;
						OFS_NTRST:  r.read_data = ntrst;
						default:    r.read_data = '0;
					endcase
				end
				MODE_WRITE: begin
					case (it.address_offset)
						OFS_CTRL: begin
							if (d[CT_RX_OFF])
								rx_on = 1'b0;
							else if (d[CT_RX_ON])
								rx_on = 1'b1;
							if (d[CT_TX_OFF])
								tx_on = 1'b0;
							else if (d[CT_TX_ON])
								tx_on = 1'b1;
							if (d[CT_CLR_STATUS])
								status &= ~ST_ERROR_BITS;
						end
						OFS_MODE: mode_reg = d;
						OFS_IEN:  irq_mask |= d;
						OFS_IDIS: irq_mask &= ~d;
						OFS_THOLD: begin
							if (tx_on) begin
								tx_hold = d[7:0];
								r.tx_valid = 1'b1;
								r.tx_byte = tx_hold;
								status |= ST_TX_BITS;
							end
						end
						OFS_BAUD:  baud = d[15:0];
						OFS_NTRST: ntrst = d;
						default: ;
					endcase
				end
				MODE_RX: begin
					if (rx_on && (status & ST_RX_READY) == '0) begin
						rx_hold = it.rx_byte;
						status |= ST_RX_READY | ST_RXBUF_FULL;
					end
				end
				default: ;
			endcase
			r.irq_line = (status & irq_mask) != '0;
			r.rx_ready = rx_on && (status & ST_RX_READY) == '0;
			pending_responses.push_back(r);
		endfunction

		function void check_response(out_item_t got);
			out_item_t exp;
			if (pending_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result item: rd=%h irq=%b txv=%b txb=%h rxr=%b",
						got.read_data, got.irq_line, got.tx_valid, got.tx_byte, got.rx_ready);
				return;
			end
			exp = pending_responses.pop_front();
			if (got.read_data !== exp.read_data || got.irq_line !== exp.irq_line ||
				got.tx_valid !== exp.tx_valid || got.tx_byte !== exp.tx_byte ||
				got.rx_ready !== exp.rx_ready) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch: expected rd=%h irq=%b txv=%b txb=%h rxr=%b, got rd=%h irq=%b txv=%b txb=%h rxr=%b",
						exp.read_data, exp.irq_line, exp.tx_valid, exp.tx_byte, exp.rx_ready,
						got.read_data, got.irq_line, got.tx_valid, got.tx_byte, got.rx_ready);
			end
		endfunction

		function int pending();
			return pending_responses.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic cfg_index;
	logic [31:0] cfg_data;
	logic sink_hold_off = 1'b0;
	int send_idle_pct = 34;
	int recv_idle_pct = 87;
	int unsigned cycle_count = 0;
	event long_stall_ev;

	dbgu_reg_shadow reg_shadow = new();

	dbgu_in_if req_ch();
	dbgu_out_if rsp_ch();

	debug_uart_register_block uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(req_ch),
		.out_ch(rsp_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				reg_shadow.note_request(req_ch.payload);
			if (rsp_ch.valid && rsp_ch.ready)
				reg_shadow.check_response(rsp_ch.payload);
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= !sink_hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	initial forever begin
		@(long_stall_ev);
		sink_hold_off <= 1'b1;
		repeat (LONG_STALL_CYCLES) @(negedge clk);
		sink_hold_off <= 1'b0;
	end

	function automatic in_item_t make_req(logic [1:0] mode, logic [8:0] ofs, logic [31:0] data,
		logic [7:0] rxb);
		in_item_t it;
		it.mode = mode;
		it.address_offset = ofs;
		it.write_data = data;
		it.rx_byte = rxb;
		return it;
	endfunction

	function automatic logic [8:0] known_offset(int idx);
		case (idx)
			0:  return OFS_CTRL;
			1:  return OFS_MODE;
			2:  return OFS_IEN;
			3:  return OFS_IDIS;
			4:  return OFS_IMASK;
			5:  return OFS_STATUS;
			6:  return OFS_RHOLD;
			7:  return OFS_THOLD;
			8:  return OFS_BAUD;
			9:  return OFS_CID;
			10: return OFS_CIDX;
			default: return OFS_NTRST;
		endcase
	endfunction

	function automatic in_item_t random_request();
		in_item_t it;
		int pick;
		it.write_data = $urandom();
		it.rx_byte = 8'($urandom());
		it.address_offset = ($urandom_range(99) < 85) ? known_offset($urandom_range(11))
			: 9'($urandom());
		pick = $urandom_range(99);
		if (pick < 35)
			it.mode = MODE_READ;
		else if (pick < 70)
			it.mode = MODE_WRITE;
		else if (pick < 97)
			it.mode = MODE_RX;
		else
			it.mode = MODE_NOP;
		// drain the receive holding register often enough for new bytes to land
		if (it.mode == MODE_READ && $urandom_range(99) < 25)
			it.address_offset = OFS_RHOLD;
		if (it.mode == MODE_WRITE && it.address_offset == OFS_CTRL && $urandom_range(99) < 70)
			it.write_data = (it.write_data & ~32'h0000_00A0) | 32'h0000_0050;
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= it;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (reg_shadow.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_chip_id(input logic idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		reg_shadow.set_chip_id(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int send_pct, input int recv_pct, input bit with_stall);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (with_stall && i == 100)
				-> long_stall_ev;
			send_item(random_request());
		end
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_index = CFG_CHIP_ID;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		rsp_ch.ready = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(make_req(MODE_READ, OFS_CID, 32'h0, 8'h00));
		send_item(make_req(MODE_READ, OFS_CIDX, 32'h0, 8'h00));
		send_item(make_req(MODE_READ, OFS_STATUS, 32'h0, 8'h00));
		send_item(make_req(MODE_RX, OFS_CTRL, 32'h0, 8'hA5));
		send_item(make_req(MODE_WRITE, OFS_THOLD, 32'h0000_005A, 8'h00));
		send_item(make_req(MODE_WRITE, OFS_CTRL, 32'h0000_00F0, 8'h00));
		send_item(make_req(MODE_WRITE, OFS_CTRL, 32'h0000_0050, 8'h00));
		send_item(make_req(MODE_WRITE, OFS_IEN, 32'hFFFF_FFFF, 8'h00));
		send_item(make_req(MODE_WRITE, OFS_IDIS, 32'hFFFF_FFFE, 8'h00));
		send_item(make_req(MODE_RX, OFS_CTRL, 32'h0, 8'hFF));
		send_item(make_req(MODE_RX, OFS_CTRL, 32'h0, 8'h00));
		send_item(make_req(MODE_READ, OFS_RHOLD, 32'h0, 8'h00));
		send_item(make_req(MODE_RX, OFS_CTRL, 32'h0, 8'h00));
		send_item(make_req(MODE_READ, OFS_RHOLD, 32'h0, 8'h00));
		send_item(make_req(MODE_WRITE, OFS_THOLD, 32'hFFFF_FFFF, 8'h00));
		send_item(make_req(MODE_WRITE, OFS_THOLD, 32'h0000_0000, 8'h00));
		send_item(make_req(MODE_WRITE, OFS_MODE, 32'hFFFF_FFFF, 8'h00));
		send_item(make_req(MODE_READ, OFS_MODE, 32'h0, 8'h00));
		send_item(make_req(MODE_WRITE, OFS_BAUD, 32'hFFFF_FFFF, 8'h00));
		send_item(make_req(MODE_READ, OFS_BAUD, 32'h0, 8'h00));
		send_item(make_req(MODE_WRITE, OFS_NTRST, 32'hFFFF_FFFF, 8'h00));
		send_item(make_req(MODE_READ, OFS_NTRST, 32'h0, 8'h00));
		send_item(make_req(MODE_WRITE, OFS_STATUS, 32'hFFFF_FFFF, 8'h00));
		send_item(make_req(MODE_WRITE, OFS_CTRL, 32'h0000_01FF, 8'h00));
		send_item(make_req(MODE_WRITE, 9'h1FF, 32'hFFFF_FFFF, 8'h00));
		send_item(make_req(MODE_READ, 9'h1FF, 32'h0, 8'h00));
		send_item(make_req(MODE_NOP, OFS_IMASK, 32'hFFFF_FFFF, 8'hFF));
		send_item(make_req(MODE_READ, OFS_IMASK, 32'h0, 8'h00));

		drain();
		write_chip_id(CFG_CHIP_ID, 32'h0000_0000);
		write_chip_id(CFG_CHIP_ID_EXT, 32'hFFFF_FFFF);
		random_phase(34, 87, 1'b0);

		drain();
		write_chip_id(CFG_CHIP_ID, 32'hFFFF_FFFF);
		write_chip_id(CFG_CHIP_ID_EXT, 32'h0000_0000);
		random_phase(87, 34, 1'b0);

		drain();
		write_chip_id(CFG_CHIP_ID, $urandom());
		write_chip_id(CFG_CHIP_ID_EXT, $urandom());
		random_phase(0, 0, 1'b1);

		drain();
		if (reg_shadow.mismatches == 0 && reg_shadow.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
